FILE: rtl/core/iira_pkg.sv
// ----------------------------------------------------------------------------
// iira_pkg: shared types and constants for the indexed insert/remove array
// Sizes, op and status codes, and the command word sent to the cell row.
// ----------------------------------------------------------------------------
`default_nettype none

package iira_pkg;

  // Storage size and word width
  localparam int DEPTH       = 16;
  localparam int VALUE_WIDTH = 32;

  // Fixed port widths
  localparam int OP_W     = 3;
  localparam int INDEX_W  = 4;
  localparam int PORT_W   = 32;
  localparam int FILL_W   = 5;
  localparam int STATUS_W = 2;

  // Derived internal widths
  localparam int STORE_W = (VALUE_WIDTH < PORT_W) ? VALUE_WIDTH : PORT_W;
  localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int CMP_W   = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;

  typedef logic [STORE_W-1:0] word_t;
  typedef logic [IDX_W-1:0]   pos_t;
  typedef logic [CNT_W-1:0]   cnt_t;

  // Operation codes
  typedef enum logic [OP_W-1:0] {
    OP_GET    = 3'd0,
    OP_SET    = 3'd1,
    OP_INSERT = 3'd2,
    OP_REMOVE = 3'd3,
    OP_PUSH   = 3'd4,
    OP_POP    = 3'd5
  } op_t;

  // Status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  // Per-cycle command broadcast along the cell row
  typedef struct packed {
    logic wr;   // overwrite the entry at pos
    logic ins;  // load at pos, cells above pos take their lower neighbor
    logic rem;  // cells at or above pos take their upper neighbor
    pos_t pos;
  } cell_cmd_t;

endpackage

`default_nettype wire

FILE: rtl/core/iira_cell.sv
// ----------------------------------------------------------------------------
// iira_cell: one storage entry of the array
// Holds one word; loads the input word, takes its lower or upper neighbor,
// or holds, according to the broadcast command and its own position.
// ----------------------------------------------------------------------------
`default_nettype none

module iira_cell (
  input  wire                  clk,
  input  iira_pkg::cell_cmd_t  cmd,
  input  iira_pkg::pos_t       cell_idx,
  input  iira_pkg::word_t      din,
  input  iira_pkg::word_t      left,
  input  iira_pkg::word_t      right,
  output iira_pkg::word_t      q
);

  // Entry register: no reset, contents are valid only below the fill count
  always_ff @(posedge clk) begin
    if (cmd.ins) begin
      if (cell_idx == cmd.pos) begin
        q <= din;
      end else if (cell_idx > cmd.pos) begin
        q <= left;
      end
    end else if (cmd.rem) begin
      if (cell_idx >= cmd.pos) begin
        q <= right;
      end
    end else if (cmd.wr && (cell_idx == cmd.pos)) begin
      q <= din;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/iira_ctrl.sv
// ----------------------------------------------------------------------------
// iira_ctrl: operation decode, fill count and result register
// Checks each command word against the fill count, drives the cell row and
// registers the result word.
// ----------------------------------------------------------------------------
`default_nettype none

module iira_ctrl (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                accept,
  input  wire  [iira_pkg::OP_W-1:0]          op,
  input  wire  [iira_pkg::INDEX_W-1:0]       index,
  input  iira_pkg::word_t                    cells [iira_pkg::DEPTH],
  output iira_pkg::cell_cmd_t                cmd,
  output logic                               done,
  output logic [iira_pkg::PORT_W-1:0]        read_value,
  output logic [iira_pkg::FILL_W-1:0]        fill_count,
  output logic [iira_pkg::STATUS_W-1:0]      status
);

  iira_pkg::cnt_t               count;
  iira_pkg::cnt_t               count_next;
  logic [iira_pkg::CMP_W-1:0]   cnt_ext;
  logic [iira_pkg::CMP_W-1:0]   idx_ext;
  logic                         full;
  logic                         empty;
  logic                         in_range;
  logic                         ins_range;
  logic                         rd_en;
  iira_pkg::pos_t               rd_pos;
  iira_pkg::status_t            st;
  iira_pkg::cell_cmd_t          c;

  assign cnt_ext   = iira_pkg::CMP_W'(count);
  assign idx_ext   = iira_pkg::CMP_W'(index);
  assign full      = (count == iira_pkg::CNT_W'(iira_pkg::DEPTH));
  assign empty     = (count == '0);
  assign in_range  = (idx_ext < cnt_ext);
  assign ins_range = (idx_ext <= cnt_ext);

  // Decode: legality checks, cell command, read select, next count
  always_comb begin
    c          = '0;
    st         = iira_pkg::ST_OK;
    rd_en      = 1'b0;
    rd_pos     = iira_pkg::IDX_W'(index);
    count_next = count;
    c.pos      = iira_pkg::IDX_W'(index);
    unique case (op)
      iira_pkg::OP_GET: begin
        if (in_range) rd_en = 1'b1;
        else          st    = iira_pkg::ST_RANGE;
      end
      iira_pkg::OP_SET: begin
        if (in_range) c.wr = 1'b1;
        else          st   = iira_pkg::ST_RANGE;
      end
      iira_pkg::OP_INSERT: begin
        if (full) begin
          st = iira_pkg::ST_FULL;
        end else if (!ins_range) begin
          st = iira_pkg::ST_RANGE;
        end else begin
          c.ins      = 1'b1;
          count_next = count + 1'b1;
        end
      end
      iira_pkg::OP_REMOVE: begin
        if (in_range) begin
          c.rem      = 1'b1;
          rd_en      = 1'b1;
          count_next = count - 1'b1;
        end else begin
          st = iira_pkg::ST_RANGE;
        end
      end
      iira_pkg::OP_PUSH: begin
        if (full) begin
          st = iira_pkg::ST_FULL;
        end else begin
          c.ins      = 1'b1;
          c.pos      = iira_pkg::IDX_W'(count);
          count_next = count + 1'b1;
        end
      end
      iira_pkg::OP_POP: begin
        if (empty) begin
          st = iira_pkg::ST_EMPTY;
        end else begin
          c.rem      = 1'b1;
          c.pos      = iira_pkg::IDX_W'(count - 1'b1);
          rd_pos     = iira_pkg::IDX_W'(count - 1'b1);
          rd_en      = 1'b1;
          count_next = count - 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Commands reach the cells only for an accepted word
  always_comb begin
    cmd     = c;
    cmd.wr  = c.wr  & accept;
    cmd.ins = c.ins & accept;
    cmd.rem = c.rem & accept;
  end

  // Fill count and result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= accept;
      if (accept) count <= count_next;
    end
  end

  // Result word: read happens before the row shifts at the same edge
  always_ff @(posedge clk) begin
    if (accept) begin
      read_value <= rd_en ? iira_pkg::PORT_W'(cells[rd_pos]) : '0;
      fill_count <= iira_pkg::FILL_W'(count_next);
      status     <= st;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/indexed_insert_remove_array.sv
// A command word accepted at an edge gives its result word, with done high,
// in the following cycle. One word is taken per cycle; busy is never raised
// since every cell shifts, loads or holds in parallel. The receiver cannot
// stall; done is high for a single cycle, results hold until the next word.
// Reset (synchronous) clears the fill count and done; entries stay undefined
// until written.
// ----------------------------------------------------------------------------
// indexed_insert_remove_array: ordered array with positional insert/remove
// A row of DEPTH cells, each holding one entry and fed by its neighbors, plus
// a controller holding the fill count and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module indexed_insert_remove_array (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                start,
  output logic                               busy,
  input  wire  [iira_pkg::OP_W-1:0]          op,
  input  wire  [iira_pkg::INDEX_W-1:0]       index,
  input  wire  [iira_pkg::PORT_W-1:0]        value,
  output logic                               done,
  output logic [iira_pkg::PORT_W-1:0]        read_value,
  output logic [iira_pkg::FILL_W-1:0]        fill_count,
  output logic [iira_pkg::STATUS_W-1:0]      status
);

  iira_pkg::word_t      cells [iira_pkg::DEPTH];
  iira_pkg::cell_cmd_t  cmd;
  iira_pkg::word_t      din;
  logic                 accept;

  // One word per cycle, never held off
  assign busy   = 1'b0;
  assign accept = start & ~busy;
  assign din    = iira_pkg::STORE_W'(value);

  iira_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .op         (op),
    .index      (index),
    .cells      (cells),
    .cmd        (cmd),
    .done       (done),
    .read_value (read_value),
    .fill_count (fill_count),
    .status     (status)
  );

  // Row of cells, each linked to its lower and upper neighbor
  for (genvar k = 0; k < iira_pkg::DEPTH; k++) begin : g_cell
    iira_pkg::word_t left_w;
    iira_pkg::word_t right_w;

    if (k == 0) begin : g_lo
      assign left_w = '0;
    end else begin : g_mid_lo
      assign left_w = cells[k-1];
    end

    if (k == iira_pkg::DEPTH - 1) begin : g_hi
      assign right_w = '0;
    end else begin : g_mid_hi
      assign right_w = cells[k+1];
    end

    iira_cell u_cell (
      .clk      (clk),
      .cmd      (cmd),
      .cell_idx (iira_pkg::IDX_W'(k)),
      .din      (din),
      .left     (left_w),
      .right    (right_w),
      .q        (cells[k])
    );
  end

endmodule

`default_nettype wire
